// ----- sv/etdq_pkg.sv -----
// Package for the epoch-tagged drop-oldest queue.
// Holds the command codes, the epoch width and the ring control struct.
// No dependencies.
`default_nettype none

package etdq_pkg;

  // Width of the source epoch and of the item epoch tag
  localparam int unsigned EPOCH_W = 32;
  // Width of the command field
  localparam int unsigned CMD_W = 2;

  // Command codes; the fourth code is a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_SRC = 2'd2
  } cmd_t;

  // Per-transaction control for the ring storage
  typedef struct packed {
    logic push;   // store one entry at the tail, dropping the head when full
    logic pop;    // read and release the head entry
    logic flush;  // empty the ring and rewind both pointers
  } ring_ctl_t;

endpackage : etdq_pkg

`default_nettype wire

// ----- sv/etdq_ring.sv -----
// Ring storage of the epoch-tagged queue: payload memory, head and tail
// pointers and fill count. Depends on etdq_pkg.
`default_nettype none

module etdq_ring
  import etdq_pkg::*;
#(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ring_ctl_t                        ctl,
  input  wire logic [PAYLOAD_BITS-1:0]          wdata,
  output logic      [PAYLOAD_BITS-1:0]          rdata,
  output logic      [$clog2(DEPTH+1)-1:0]       count,
  output logic                                  full,
  output logic                                  empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [PAYLOAD_BITS-1:0] mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] rdata_r;
  logic [PTR_W-1:0]        head_r, head_nxt;
  logic [PTR_W-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [PTR_W-1:0]        head_inc, tail_inc;

  // Advance pointers with wrap at the last slot
  assign head_inc = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Pointer and count update; a push into a full ring drops the head
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.flush) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (ctl.push) begin
      tail_nxt = tail_inc;
      if (full) begin
        head_nxt = head_inc;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (ctl.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Write the tail slot on push
  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.flush) begin
      mem[tail_r] <= wdata;
    end
  end

  // Read the head slot on pop into a register; data is valid in the cycle after the pop
  always_ff @(posedge clk) begin
    if (ctl.pop && !ctl.flush && !ctl.push) begin
      rdata_r <= mem[head_r];
    end
  end

  assign rdata = rdata_r;
  assign count = count_r;

endmodule : etdq_ring

`default_nettype wire

// ----- sv/epoch_tagged_drop_oldest_queue_unit.sv -----
// Top level of the epoch-tagged drop-oldest work queue.
// Depends on etdq_pkg and etdq_ring.
//
// Usage:
//   Command channel: drive in_cmd, in_kind, in_epoch and in_payload with
//   start high; the transaction is taken at the rising edge where start is
//   high and busy is low. busy stays low, so one transaction can be issued
//   every cycle.
//   Result channel: exactly one result per transaction, shown on the out_
//   ports for one cycle with out_strobe high, in the cycle right after the
//   transaction was taken (throughput 1 per cycle). The dequeued payload
//   comes from the ring memory's registered read port, which keeps it
//   aligned with the strobe; pointer and count updates are single step,
//   so back-to-back enqueue and dequeue of the same slot are safe.
//   Enqueue stores only when a source kind is set and both kind and epoch
//   match; a full ring drops its oldest entry. Set source flushes the ring,
//   loads the kind and advances the epoch, skipping zero.
//   Reset (rst_n low, synchronous) empties the ring, clears the kind and
//   sets the epoch to one; no strobe follows reset. The receiver cannot
//   stall: each result is valid for its one strobe cycle only.
`default_nettype none

module epoch_tagged_drop_oldest_queue_unit
  import etdq_pkg::*;
#(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned KIND_BITS    = 3,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [CMD_W-1:0]             in_cmd,
  input  wire logic [KIND_BITS-1:0]         in_kind,
  input  wire logic [EPOCH_W-1:0]           in_epoch,
  input  wire logic [PAYLOAD_BITS-1:0]      in_payload,
  // Result channel
  output logic                              out_strobe,
  output logic                              out_accepted,
  output logic                              out_dropped_oldest,
  output logic                              out_valid,
  output logic      [PAYLOAD_BITS-1:0]      out_payload,
  output logic      [$clog2(DEPTH+1)-1:0]   out_level,
  output logic      [KIND_BITS-1:0]         out_cur_kind,
  output logic      [EPOCH_W-1:0]           out_cur_epoch
);

  logic                    take;
  ring_ctl_t               ctl;
  logic [PAYLOAD_BITS-1:0] rdata;
  logic                    full, empty;
  logic                    match;

  logic                    strobe_r;
  logic                    accepted_r, accepted_nxt;
  logic                    dropped_r, dropped_nxt;
  logic                    valid_r;
  logic [KIND_BITS-1:0]    kind_r, kind_nxt;
  logic [EPOCH_W-1:0]      epoch_r, epoch_nxt, epoch_inc;

  assign busy = 1'b0;
  assign take = start && !busy;

  // Enqueue needs a source set and matching kind and epoch
  assign match = (kind_r != '0) && (in_kind == kind_r) && (in_epoch == epoch_r);

  // Epoch plus one; the skip past zero is applied on set source
  assign epoch_inc = epoch_r + EPOCH_W'(1);

  // Decode the transaction into ring control and source updates
  always_comb begin
    ctl          = '0;
    accepted_nxt = 1'b0;
    dropped_nxt  = 1'b0;
    kind_nxt     = kind_r;
    epoch_nxt    = epoch_r;
    if (take) begin
      unique case (cmd_t'(in_cmd))
        CMD_ENQ: begin
          ctl.push     = match;
          accepted_nxt = match;
          dropped_nxt  = match && full;
        end
        CMD_DEQ: begin
          ctl.pop = !empty;
        end
        CMD_SRC: begin
          ctl.flush = 1'b1;
          kind_nxt  = in_kind;
          epoch_nxt = (epoch_inc == '0) ? EPOCH_W'(1) : epoch_inc;
        end
        default: begin
        end
      endcase
    end
  end

  etdq_ring #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .wdata (in_payload),
    .rdata (rdata),
    .count (out_level),
    .full  (full),
    .empty (empty)
  );

  // Hold source state and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r   <= 1'b0;
      accepted_r <= 1'b0;
      dropped_r  <= 1'b0;
      valid_r    <= 1'b0;
      kind_r     <= '0;
      epoch_r    <= EPOCH_W'(1);
    end else begin
      strobe_r   <= take;
      accepted_r <= accepted_nxt;
      dropped_r  <= dropped_nxt;
      valid_r    <= ctl.pop;
      kind_r     <= kind_nxt;
      epoch_r    <= epoch_nxt;
    end
  end

  // Drive the result; status fields read the post-transaction state
  assign out_strobe         = strobe_r;
  assign out_accepted       = accepted_r;
  assign out_dropped_oldest = dropped_r;
  assign out_valid          = valid_r;
  assign out_payload        = valid_r ? rdata : '0;
  assign out_cur_kind       = kind_r;
  assign out_cur_epoch      = epoch_r;

endmodule : epoch_tagged_drop_oldest_queue_unit

`default_nettype wire

// ----- verif/tb_epoch_tagged_drop_oldest_queue_unit.sv -----
// Self-checking testbench for epoch_tagged_drop_oldest_queue_unit.
// Drives enqueue, dequeue, set-source and no-op transactions and predicts each status result.
// Depends on etdq_pkg and the queue RTL only.

module tb_epoch_tagged_drop_oldest_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import etdq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned KIND_BITS    = 3;
  localparam int unsigned PAYLOAD_BITS = 64;
  localparam int unsigned LEVEL_W      = $clog2(DEPTH + 1);
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned SETTLE_CYC   = 4;
  // Spare command code; the block treats it as a no-op
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // One status result as the block reports it
  typedef struct packed {
    logic                    accepted;
    logic                    dropped;
    logic                    valid;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [LEVEL_W-1:0]      level;
    logic [KIND_BITS-1:0]    kind;
    logic [EPOCH_W-1:0]      epoch;
  } queue_status_t;

  // Shadow of the work queue: predicts the status of each command and
  // checks it against what the block reports.
  class work_queue_tracker;
    logic [PAYLOAD_BITS-1:0] held_payloads[$];
    logic [KIND_BITS-1:0]    src_kind;
    logic [EPOCH_W-1:0]      src_epoch;
    queue_status_t           pending_status[$];
    int                      mismatches;

    function new();
      src_kind   = '0;
      src_epoch  = 1;
      mismatches = 0;
    endfunction

    // Apply one accepted command and queue the status it must produce
    function void note_command(logic [CMD_W-1:0] cmd, logic [KIND_BITS-1:0] kind,
                               logic [EPOCH_W-1:0] epoch,
                               logic [PAYLOAD_BITS-1:0] payload);
      queue_status_t s;
      s = '0;
      case (cmd)
        CMD_ENQ: begin
          if (src_kind != 0 && kind == src_kind && epoch == src_epoch) begin
            // drop the oldest entry to make room
            if (held_payloads.size() >= DEPTH) begin
              void'(held_payloads.pop_front());
              s.dropped = 1'b1;
            end
            held_payloads.push_back(payload);
            s.accepted = 1'b1;
          end
        end
        CMD_DEQ: begin
          if (held_payloads.size() > 0) begin
            s.payload = held_payloads.pop_front();
            s.valid   = 1'b1;
          end
        end
        CMD_SRC: begin
          // flush, load the kind and advance the epoch past zero
          held_payloads.delete();
          src_kind  = kind;
          src_epoch = src_epoch + 1;
          if (src_epoch == 0) src_epoch = 1;
        end
        default: ;
      endcase
      s.level = LEVEL_W'(held_payloads.size());
      s.kind  = src_kind;
      s.epoch = src_epoch;
      pending_status.push_back(s);
    endfunction

    function void compare_field(string label, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, label, want, got);
        mismatches++;
      end
    endfunction

    // Compare one strobed result with the oldest prediction
    function void check_status(queue_status_t got);
      queue_status_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual level %0d payload 0x%0h",
                 $time, got.level, got.payload);
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("dropped_oldest", want.dropped, got.dropped);
      compare_field("out_valid", want.valid, got.valid);
      compare_field("out_payload", want.payload, got.payload);
      compare_field("level", want.level, got.level);
      compare_field("cur_kind", want.kind, got.kind);
      compare_field("cur_epoch", want.epoch, got.epoch);
    endfunction
  endclass

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    start      = 1'b0;
  logic [CMD_W-1:0]        in_cmd     = '0;
  logic [KIND_BITS-1:0]    in_kind    = '0;
  logic [EPOCH_W-1:0]      in_epoch   = '0;
  logic [PAYLOAD_BITS-1:0] in_payload = '0;
  logic                    busy;
  logic                    out_strobe;
  logic                    out_accepted;
  logic                    out_dropped_oldest;
  logic                    out_valid;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [LEVEL_W-1:0]      out_level;
  logic [KIND_BITS-1:0]    out_cur_kind;
  logic [EPOCH_W-1:0]      out_cur_epoch;

  work_queue_tracker tracker = new();

  // Sender-side view of the source, so well-formed enqueues can be built
  logic [KIND_BITS-1:0] drv_kind  = '0;
  logic [EPOCH_W-1:0]   drv_epoch = 1;
  bit                   gaps_on   = 1'b0;
  int unsigned          stall_cyc = 0;

  epoch_tagged_drop_oldest_queue_unit #(
    .DEPTH       (DEPTH),
    .KIND_BITS   (KIND_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_kind           (in_kind),
    .in_epoch          (in_epoch),
    .in_payload        (in_payload),
    .out_strobe        (out_strobe),
    .out_accepted      (out_accepted),
    .out_dropped_oldest(out_dropped_oldest),
    .out_valid         (out_valid),
    .out_payload       (out_payload),
    .out_level         (out_level),
    .out_cur_kind      (out_cur_kind),
    .out_cur_epoch     (out_cur_epoch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Check results first, then record the transaction taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        tracker.check_status({out_accepted, out_dropped_oldest, out_valid, out_payload,
                              out_level, out_cur_kind, out_cur_epoch});
      if (start && !busy)
        tracker.note_command(in_cmd, in_kind, in_epoch, in_payload);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cyc <= 0;
    end else begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [PAYLOAD_BITS-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // Offer one transaction and hold it until the block takes it
  task automatic send_txn(logic [CMD_W-1:0] cmd, logic [KIND_BITS-1:0] kind,
                          logic [EPOCH_W-1:0] epoch, logic [PAYLOAD_BITS-1:0] payload);
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_kind    <= kind;
    in_epoch   <= epoch;
    in_payload <= payload;
    if (cmd == CMD_SRC) begin
      drv_kind  = kind;
      drv_epoch = drv_epoch + 1;
      if (drv_epoch == 0) drv_epoch = 1;
    end
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_txn(CMD_DEQ, '0, '0, '0);                      // dequeue on empty
    send_txn(CMD_ENQ, '0, drv_epoch, rand_payload());   // no source yet
    send_txn(CMD_SRC, 3'd7, '0, '0);
    send_txn(CMD_ENQ, 3'd7, drv_epoch, '1);
    send_txn(CMD_ENQ, 3'd7, '1, rand_payload());        // stale epoch
    send_txn(CMD_ENQ, 3'd3, drv_epoch, rand_payload()); // wrong kind
    send_txn(CMD_NOP, 3'd7, drv_epoch, '1);
    // overfill so the last store drops the oldest entry
    for (int i = 0; i < DEPTH; i++)
      send_txn(CMD_ENQ, 3'd7, drv_epoch, (i == 0) ? '0 : rand_payload());
    send_txn(CMD_DEQ, '0, '0, '0);
    send_txn(CMD_SRC, '0, '1, '1);                      // source kind none
    send_txn(CMD_ENQ, '0, drv_epoch, rand_payload());
    send_txn(CMD_DEQ, '1, '1, '1);
  endtask

  // Mostly well-formed enqueues and dequeues; the rest is noise
  task automatic run_random(int unsigned count, int unsigned enq_pct, int unsigned deq_pct);
    int unsigned          pick;
    int unsigned          sub;
    logic [KIND_BITS-1:0] kind;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 9);
      if (pick < enq_pct) begin
        send_txn(CMD_ENQ, drv_kind, drv_epoch, rand_payload());
      end else if (pick < enq_pct + deq_pct) begin
        send_txn(CMD_DEQ, KIND_BITS'($urandom), $urandom, rand_payload());
      end else if (sub < 2) begin
        kind = ($urandom_range(0, 99) < 15) ? '0 : KIND_BITS'($urandom_range(1, 7));
        send_txn(CMD_SRC, kind, $urandom, rand_payload());
      end else if (sub < 4) begin
        // wrong kind
        send_txn(CMD_ENQ, drv_kind ^ KIND_BITS'($urandom_range(1, 7)), drv_epoch,
                 rand_payload());
      end else if (sub < 6) begin
        // stale or random epoch tag
        send_txn(CMD_ENQ, drv_kind, ($urandom_range(0, 1) != 0) ?
                 drv_epoch - $urandom_range(1, 3) : $urandom, rand_payload());
      end else if (sub < 8) begin
        send_txn(CMD_NOP, KIND_BITS'($urandom), $urandom, rand_payload());
      end else begin
        send_txn(CMD_ENQ, KIND_BITS'($urandom), $urandom, rand_payload());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain();

    // long burst with no gaps, leaning on overflow
    gaps_on = 1'b0;
    run_random(200, 55, 25);
    drain();

    gaps_on = 1'b1;
    run_random(200, 30, 50);
    drain();
    run_random(200, 40, 40);
    drain();

    repeat (SETTLE_CYC) @(posedge clk);
    if (tracker.pending_status.size() != 0) begin
      $display("%0t: expected %0d more results, actual 0", $time,
               tracker.pending_status.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
